### design/neighbor_contact_time_tracker_top_assert.svh
// assertion macros for the neighbor contact-time tracker top level
// expects clk and rst_n in the scope where a macro is used
`ifndef NEIGHBOR_CONTACT_TIME_TRACKER_TOP_ASSERT_SVH
`define NEIGHBOR_CONTACT_TIME_TRACKER_TOP_ASSERT_SVH

// same-cycle implication
`define NCTA_ASSERT_IMPLY(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("ncta check failed");

// next-cycle implication
`define NCTA_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("ncta check failed");

`endif

### design/ncta_pkg.sv
// shared types and constants of the neighbor contact-time tracker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ncta_pkg;

  localparam int TABLE_SIZE = 32;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int KEY_W      = 16;
  localparam int TIME_W     = 32;
  localparam int LIM_W      = 16;
  localparam int SUM_W      = TIME_W + CNT_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [LIM_W-1:0] BEACON_LIMIT_RST = 16'd1050;
  localparam logic [LIM_W-1:0] ROUND_LIMIT_RST  = 16'd1100;

  localparam logic [CFG_IDX_W-1:0] CFG_BEACON_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_LIMIT  = 2'd1;

  localparam logic OP_BEACON = 1'b0;
  localparam logic OP_ROUND  = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] last;
    logic [TIME_W-1:0] contact;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### design/neighbor_contact_time_tracker_top.sv
// Neighbor contact-time tracker. Keys, last-heard times and contact totals
// live in one TABLE_SIZE-entry ram; the used bits are flip-flops cleared at
// reset. One item is in work at a time: every item sweeps the ram read port
// one entry per cycle, doing a beacon's lookup and free-slot search and the
// aging in that single pass. A beacon then writes its entry back in the
// write state, or is marked dropped when it finds neither a hit nor a free
// slot. A round sums nonzero contacts during the sweep and then runs the
// bit-serial divider; a round with no nonzero contact skips the divider.
// The result sits in an output register, so the next item can be taken in
// the cycle after the result is loaded, while it waits.
// depends on ncta_pkg, ncta_ram, ncta_div and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "neighbor_contact_time_tracker_top_assert.svh"

module neighbor_contact_time_tracker_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_op,
  input  wire logic [ncta_pkg::KEY_W-1:0]     in_source_id,
  input  wire logic [ncta_pkg::TIME_W-1:0]    in_now_ms,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ncta_pkg::TIME_W-1:0]         out_mean_contact_ms,
  output logic                                out_mean_valid,
  output logic                                out_dropped,
  input  wire logic                           cfg_we,
  input  wire logic [ncta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ncta_pkg::LIM_W-1:0]     cfg_wdata
);
  import ncta_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SWEEP  = 3'd1;
  localparam logic [2:0] ST_WRITE  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [LIM_W-1:0]      beacon_lim_r, round_lim_r;
  logic [TABLE_SIZE-1:0] used_r, used_nxt;

  logic                  op_r;
  logic [KEY_W-1:0]      id_r;
  logic [TIME_W-1:0]     now_r;
  logic [LIM_W-1:0]      lim_r;

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]      rd_idx_r;

  logic                  hit_f_r, hit_f_nxt;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic [TIME_W-1:0]     hit_gap_r, hit_gap_nxt;
  logic [TIME_W-1:0]     hit_contact_r, hit_contact_nxt;
  logic                  free_f_r, free_f_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;

  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic [TIME_W-1:0]     res_mean_r, res_mean_nxt;
  logic                  res_valid_r, res_valid_nxt;
  logic                  res_drop_r, res_drop_nxt;

  logic                  out_valid_r;
  logic [TIME_W-1:0]     out_mean_r;
  logic                  out_mv_r;
  logic                  out_drop_r;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  entry_t                ram_wentry;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                rd_entry;
  logic                  rd_used;
  logic [TIME_W-1:0]     gap;
  logic                  aged;
  logic [TIME_W:0]       sat_sum;
  logic [TIME_W-1:0]     new_contact;

  logic                  div_start;
  logic                  div_done;
  logic [TIME_W-1:0]     div_quot;

  logic                  in_fire;
  logic                  load_out;

  ncta_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SIZE)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wentry),
    .raddr(cnt_r[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  ncta_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(sum_r),
    .divisor (count_r),
    .done    (div_done),
    .quotient(div_quot)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign load_out = (state_r == ST_RESULT) && (!out_valid_r || out_ready);

  // entry coming back from the ram this cycle
  assign rd_entry = entry_t'(ram_rdata);
  assign rd_used  = used_r[rd_idx_r];
  assign gap      = (now_r >= rd_entry.last) ? (now_r - rd_entry.last) : '0;
  assign aged     = gap > {{(TIME_W - LIM_W){1'b0}}, lim_r};

  // saturating contact update for a hit, restarting from zero past the beacon limit
  assign sat_sum  = {1'b0, hit_contact_r} + {1'b0, hit_gap_r};
  always_comb begin
    if (hit_gap_r > {{(TIME_W - LIM_W){1'b0}}, beacon_lim_r}) begin
      new_contact = '0;
    end else if (sat_sum[TIME_W]) begin
      new_contact = '1;
    end else begin
      new_contact = sat_sum[TIME_W-1:0];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    used_nxt        = used_r;
    cnt_nxt         = cnt_r;
    rd_vld_nxt      = 1'b0;
    hit_f_nxt       = hit_f_r;
    hit_idx_nxt     = hit_idx_r;
    hit_gap_nxt     = hit_gap_r;
    hit_contact_nxt = hit_contact_r;
    free_f_nxt      = free_f_r;
    free_idx_nxt    = free_idx_r;
    sum_nxt         = sum_r;
    count_nxt       = count_r;
    res_mean_nxt    = res_mean_r;
    res_valid_nxt   = res_valid_r;
    res_drop_nxt    = res_drop_r;
    ram_we          = 1'b0;
    ram_waddr       = hit_idx_r;
    ram_wentry      = '{key: id_r, last: now_r, contact: new_contact};
    div_start       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_nxt       = '0;
          hit_f_nxt     = 1'b0;
          free_f_nxt    = 1'b0;
          sum_nxt       = '0;
          count_nxt     = '0;
          res_mean_nxt  = '0;
          res_valid_nxt = 1'b0;
          res_drop_nxt  = 1'b0;
          state_nxt     = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (cnt_r != CNT_W'(TABLE_SIZE)) begin
          rd_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (op_r == OP_BEACON) begin
            // lookup and free search see used bits before this item ages them
            if (rd_used) begin
              if (rd_entry.key == id_r && !hit_f_r) begin
                hit_f_nxt       = 1'b1;
                hit_idx_nxt     = rd_idx_r;
                hit_gap_nxt     = gap;
                hit_contact_nxt = rd_entry.contact;
              end else if (aged) begin
                used_nxt[rd_idx_r] = 1'b0;
              end
            end else if (!free_f_r) begin
              free_f_nxt   = 1'b1;
              free_idx_nxt = rd_idx_r;
            end
          end else if (rd_used) begin
            if (aged) begin
              used_nxt[rd_idx_r] = 1'b0;
            end else if (rd_entry.contact != '0) begin
              sum_nxt   = sum_r + {{CNT_W{1'b0}}, rd_entry.contact};
              count_nxt = count_r + 1'b1;
            end
          end
        end else if (cnt_r == CNT_W'(TABLE_SIZE)) begin
          if (op_r == OP_BEACON) begin
            state_nxt = ST_WRITE;
          end else if (count_r != '0) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_WRITE: begin
        // the sweep is over, so this write cannot race a read of the entry
        if (hit_f_r) begin
          ram_we = 1'b1;
        end else if (free_f_r) begin
          ram_we             = 1'b1;
          ram_waddr          = free_idx_r;
          ram_wentry.contact = '0;
          used_nxt[free_idx_r] = 1'b1;
        end else begin
          res_drop_nxt = 1'b1;
        end
        state_nxt = ST_RESULT;
      end
      ST_DIV: begin
        if (div_done) begin
          res_mean_nxt  = div_quot;
          res_valid_nxt = 1'b1;
          state_nxt     = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_r       <= '0;
      rd_vld_r     <= 1'b0;
      cnt_r        <= '0;
      hit_f_r      <= 1'b0;
      free_f_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      beacon_lim_r <= BEACON_LIMIT_RST;
      round_lim_r  <= ROUND_LIMIT_RST;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      rd_vld_r <= rd_vld_nxt;
      cnt_r    <= cnt_nxt;
      hit_f_r  <= hit_f_nxt;
      free_f_r <= free_f_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BEACON_LIMIT: beacon_lim_r <= cfg_wdata;
          CFG_ROUND_LIMIT:  round_lim_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
    rd_idx_r      <= cnt_r[IDX_W-1:0];
    hit_idx_r     <= hit_idx_nxt;
    hit_gap_r     <= hit_gap_nxt;
    hit_contact_r <= hit_contact_nxt;
    free_idx_r    <= free_idx_nxt;
    sum_r         <= sum_nxt;
    count_r       <= count_nxt;
    res_mean_r    <= res_mean_nxt;
    res_valid_r   <= res_valid_nxt;
    res_drop_r    <= res_drop_nxt;
    if (in_fire) begin
      op_r  <= in_op;
      id_r  <= in_source_id;
      now_r <= in_now_ms;
      lim_r <= (in_op == OP_ROUND) ? round_lim_r : beacon_lim_r;
    end
    if (load_out) begin
      out_mean_r <= res_mean_r;
      out_mv_r   <= res_valid_r;
      out_drop_r <= res_drop_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mean_contact_ms = out_mean_r;
  assign out_mean_valid      = out_mv_r;
  assign out_dropped         = out_drop_r;

  `NCTA_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready)
  `NCTA_ASSERT_IMPLY(a_div_nonzero, div_start, count_r != '0)
  `NCTA_ASSERT_IMPLY(a_insert_free, ram_we && !hit_f_r, !used_r[free_idx_r])
  `NCTA_ASSERT_IMPLY(a_result_kind, out_valid && out_mean_valid, !out_dropped)

endmodule

`default_nettype wire

### design/ncta_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ncta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/ncta_div.sv
// restoring divider, one quotient bit per cycle, for the mean contact time
// depends on ncta_pkg
`timescale 1ns / 1ps
`default_nettype none

module ncta_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [ncta_pkg::SUM_W-1:0] dividend,
  input  wire logic [ncta_pkg::CNT_W-1:0] divisor,
  output logic                            done,
  output logic [ncta_pkg::TIME_W-1:0]     quotient
);
  import ncta_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  dq_r, dq_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign shifted = {rem_r, dq_r[SUM_W-1]};
  assign ge      = shifted >= {1'b0, div_r};
  assign diff    = shifted - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dq_nxt   = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      dq_nxt   = {dq_r[SUM_W-2:0], ge};
      rem_nxt  = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r[TIME_W-1:0];

endmodule

`default_nettype wire

### tb/ncta_checker.sv
`timescale 1ns / 1ps
// checker for the neighbor contact-time tracker: mirrors the neighbor table,
// predicts one result per accepted item and compares it on the result channel
// depends on ncta_pkg

module ncta_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_op,
  input  logic [ncta_pkg::KEY_W-1:0]     in_source_id,
  input  logic [ncta_pkg::TIME_W-1:0]    in_now_ms,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [ncta_pkg::TIME_W-1:0]    out_mean_contact_ms,
  input  logic                           out_mean_valid,
  input  logic                           out_dropped,
  input  logic                           cfg_we,
  input  logic [ncta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ncta_pkg::LIM_W-1:0]     cfg_wdata,
  output int unsigned                    fail_count,
  output int unsigned                    outstanding
);
  import ncta_pkg::*;

  typedef struct packed {
    logic [TIME_W-1:0] mean;
    logic              mean_valid;
    logic              dropped;
  } tracker_result_t;

  logic [LIM_W-1:0]  beacon_limit;
  logic [LIM_W-1:0]  round_limit;
  logic              slot_used    [TABLE_SIZE];
  logic [KEY_W-1:0]  slot_key     [TABLE_SIZE];
  logic [TIME_W-1:0] slot_heard   [TABLE_SIZE];
  logic [TIME_W-1:0] slot_contact [TABLE_SIZE];
  tracker_result_t   owed_results [$];

  // time running backwards counts as no gap
  function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now,
                                                 input logic [TIME_W-1:0] heard);
    return (now >= heard) ? now - heard : '0;
  endfunction

  function automatic void expire_stale(input logic [TIME_W-1:0] now,
                                       input logic [LIM_W-1:0] limit);
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (slot_used[i] && elapsed(now, slot_heard[i]) > limit) begin
        slot_used[i]    = 1'b0;
        slot_contact[i] = '0;
      end
    end
  endfunction

  function automatic tracker_result_t track_neighbor(input logic              op,
                                                     input logic [KEY_W-1:0]  id,
                                                     input logic [TIME_W-1:0] now);
    int                hit;
    int                free_slot;
    logic [TIME_W-1:0] gap;
    logic [TIME_W:0]   grown;
    logic [63:0]       sum;
    logic [63:0]       count;
    tracker_result_t   r;
    r         = '0;
    hit       = -1;
    free_slot = -1;
    sum       = '0;
    count     = '0;
    if (op == OP_BEACON) begin
      // lookup and free search happen before aging
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (slot_used[i]) begin
          if (hit < 0 && slot_key[i] == id) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit >= 0) begin
        gap = elapsed(now, slot_heard[hit]);
        if (gap <= beacon_limit) begin
          grown             = {1'b0, slot_contact[hit]} + {1'b0, gap};
          slot_contact[hit] = grown[TIME_W] ? '1 : grown[TIME_W-1:0];
        end else begin
          slot_contact[hit] = '0;
        end
        slot_heard[hit] = now;
      end else if (free_slot >= 0) begin
        slot_used[free_slot]    = 1'b1;
        slot_key[free_slot]     = id;
        slot_heard[free_slot]   = now;
        slot_contact[free_slot] = '0;
      end else begin
        r.dropped = 1'b1;
      end
      expire_stale(now, beacon_limit);
    end else begin
      expire_stale(now, round_limit);
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (slot_used[i] && slot_contact[i] != '0) begin
          sum   = sum + 64'(slot_contact[i]);
          count = count + 64'd1;
        end
      end
      if (count != '0) begin
        sum          = sum / count;
        r.mean       = sum[TIME_W-1:0];
        r.mean_valid = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    tracker_result_t want;
    tracker_result_t fresh;
    if (!rst_n) begin
      beacon_limit = BEACON_LIMIT_RST;
      round_limit  = ROUND_LIMIT_RST;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        slot_used[i]    = 1'b0;
        slot_key[i]     = '0;
        slot_heard[i]   = '0;
        slot_contact[i] = '0;
      end
      owed_results.delete();
      outstanding = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BEACON_LIMIT: beacon_limit = cfg_wdata;
          CFG_ROUND_LIMIT:  round_limit  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        fresh        = track_neighbor(in_op, in_source_id, in_now_ms);
        owed_results = {owed_results, fresh};
      end
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result with no item outstanding, mean", out_mean_contact_ms, '0);
        end else begin
          want = owed_results.pop_front();
          if (out_mean_contact_ms !== want.mean)
            report_mismatch("mean_contact_ms", out_mean_contact_ms, want.mean);
          if (out_mean_valid !== want.mean_valid)
            report_mismatch("mean_valid", TIME_W'(out_mean_valid), TIME_W'(want.mean_valid));
          if (out_dropped !== want.dropped)
            report_mismatch("dropped", TIME_W'(out_dropped), TIME_W'(want.dropped));
        end
      end
      outstanding = owed_results.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// top of the neighbor contact-time tracker testbench: clock, reset, stimulus,
// limit register writes and the verdict
// depends on ncta_pkg, ncta_checker and neighbor_contact_time_tracker_top

module tb;
  import ncta_pkg::*;

  localparam int ITEM_GOAL    = 1350;
  localparam int CALM_ITEMS   = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic                 in_op        = OP_BEACON;
  logic [KEY_W-1:0]     in_source_id = '0;
  logic [TIME_W-1:0]    in_now_ms    = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [TIME_W-1:0]    out_mean_contact_ms;
  logic                 out_mean_valid;
  logic                 out_dropped;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_BEACON_LIMIT;
  logic [LIM_W-1:0]     cfg_wdata    = '0;

  int unsigned       fail_count;
  int unsigned       outstanding;
  bit                calm;
  int                idle_pct    = 20;
  int                stall_pct   = 20;
  int                stall_left  = 0;
  int                quiet_cycles = 0;
  int                items_sent  = 0;
  logic [TIME_W-1:0] clock_ms    = '0;
  logic [LIM_W-1:0]  beacon_lim  = BEACON_LIMIT_RST;
  logic [LIM_W-1:0]  round_lim   = ROUND_LIMIT_RST;
  logic [KEY_W-1:0]  pool [$];

  neighbor_contact_time_tracker_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_source_id        (in_source_id),
    .in_now_ms           (in_now_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_mean_contact_ms (out_mean_contact_ms),
    .out_mean_valid      (out_mean_valid),
    .out_dropped         (out_dropped),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  ncta_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_source_id        (in_source_id),
    .in_now_ms           (in_now_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_mean_contact_ms (out_mean_contact_ms),
    .out_mean_valid      (out_mean_valid),
    .out_dropped         (out_dropped),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .fail_count          (fail_count),
    .outstanding         (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side back-pressure in short random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_item(input logic op, input logic [KEY_W-1:0] id,
                           input logic [TIME_W-1:0] now);
    int gap_cycles;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap_cycles = $urandom_range(1, 5);
      in_valid   = 1'b0;
      repeat (gap_cycles) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_op        = op;
    in_source_id = id;
    in_now_ms    = now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_limits(input logic [LIM_W-1:0] beacon_val,
                              input logic [LIM_W-1:0] round_val);
    beacon_lim = beacon_val;
    round_lim  = round_val;
    cfg_we     = 1'b1;
    cfg_index  = CFG_BEACON_LIMIT;
    cfg_wdata  = beacon_val;
    @(negedge clk);
    cfg_index  = CFG_ROUND_LIMIT;
    cfg_wdata  = round_val;
    @(negedge clk);
    cfg_we     = 1'b0;
  endtask

  function automatic logic [LIM_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return LIM_W'($urandom);
      3:       return LIM_W'($urandom_range(1, 64));
      4:       return BEACON_LIMIT_RST;
      default: return LIM_W'($urandom_range(500, 3000));
    endcase
  endfunction

  // mostly small steps, sometimes long silences, now and then time runs back
  function automatic void advance_clock(input int unsigned span);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3)
      clock_ms = clock_ms - $urandom_range(1, 2000);
    else if (roll < 10)
      clock_ms = clock_ms + $urandom_range(0, 3 * beacon_lim + 3);
    else
      clock_ms = clock_ms + $urandom_range(0, span);
  endfunction

  // fill_first inserts more distinct neighbors than the table holds
  task automatic run_phase(input bit fill_first);
    int               length;
    int               pool_n;
    int unsigned      span;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] id;
    pool.delete();
    pool_n = fill_first ? TABLE_SIZE + 8 : $urandom_range(1, TABLE_SIZE + 8);
    base   = KEY_W'($urandom);
    for (int k = 0; k < pool_n; k++) begin
      id   = fill_first ? base + KEY_W'(k) : KEY_W'($urandom);
      pool = {pool, id};
    end
    span      = fill_first ? 20 : (beacon_lim + beacon_lim / 4) / pool_n + 2;
    length    = $urandom_range(40, 120);
    idle_pct  = 10 * $urandom_range(0, 4);
    stall_pct = 10 * $urandom_range(0, 4);
    if (!fill_first && $urandom_range(0, 1)) clock_ms = $urandom;
    for (int n = 0; n < length && items_sent < ITEM_GOAL; n++) begin
      calm = (items_sent >= ITEM_GOAL - CALM_ITEMS);
      advance_clock(span);
      if (fill_first && n < pool_n) begin
        send_item(OP_BEACON, pool[n], clock_ms);
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:11]:  send_item(OP_ROUND, KEY_W'($urandom), clock_ms);
          [12:16]: send_item(OP_BEACON, KEY_W'($urandom), clock_ms);
          default: send_item(OP_BEACON, pool[$urandom_range(0, pool_n - 1)], clock_ms);
        endcase
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset limits: beacon 1050, round 1100
    send_item(OP_ROUND,  16'h0000, 32'd0);        // empty table, no mean
    send_item(OP_BEACON, 16'h0000, 32'd0);
    send_item(OP_BEACON, 16'hFFFF, 32'd10);
    send_item(OP_BEACON, 16'h0000, 32'd1050);     // gap right at the limit
    send_item(OP_BEACON, 16'hFFFF, 32'd2091);     // gap over the limit, contact restarts
    send_item(OP_ROUND,  16'hFFFF, 32'd2100);
    send_item(OP_BEACON, 16'h0000, 32'd2000);     // time ran backwards
    send_item(OP_ROUND,  16'h0000, 32'd3101);     // one aged out, rest has no contact
    send_item(OP_BEACON, 16'h5A5A, 32'd3101);
    send_item(OP_BEACON, 16'h5A5A, 32'd3500);
    send_item(OP_BEACON, 16'hFFFF, 32'd3600);
    send_item(OP_BEACON, 16'hFFFF, 32'd4000);
    send_item(OP_ROUND,  16'h0000, 32'd4000);     // mean truncates
    send_item(OP_BEACON, 16'hA5A5, 32'hFFFF_FF00);
    send_item(OP_BEACON, 16'hA5A5, 32'hFFFF_FFFF);
    send_item(OP_ROUND,  16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_ROUND,  16'h1234, 32'hFFFF_FFFF);
    clock_ms = 32'hFFFF_FFFF;

    wait_idle();
    write_limits('1, '1);
    run_phase(1'b1);
    while (items_sent < ITEM_GOAL) begin
      wait_idle();
      write_limits(pick_limit(), pick_limit());
      run_phase(1'b0);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/ncta_pkg.sv
design/ncta_ram.sv
design/ncta_div.sv
design/neighbor_contact_time_tracker_top.sv
tb/ncta_checker.sv
tb/tb.sv
